// ----- sv/sapq_pkg.sv -----
// ----------------------------------------------------------------------------
// Sorted arrival priority queue package
// Shared types, command codes and the queue depth.
// ----------------------------------------------------------------------------
`default_nettype none

package sapq_pkg;

  localparam int QUEUE_DEPTH = 16;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_POP    = 1'b1
  } cmd_t;

  typedef struct packed {
    logic        command;
    logic [15:0] arrival_time;
    logic [2:0]  priority_level;
    logic [15:0] cpu_time;
    logic [13:0] memory_need;
    logic [1:0]  printers_need;
    logic        scanners_need;
    logic        modems_need;
    logic [1:0]  discs_need;
    logic [9:0]  process_number;
    logic [15:0] time_left;
  } in_item_t;

  typedef struct packed {
    logic        head_valid;
    logic [15:0] out_arrival;
    logic [2:0]  out_priority;
    logic [15:0] out_cpu_time;
    logic [13:0] out_memory;
    logic [1:0]  out_printers;
    logic        out_scanners;
    logic        out_modems;
    logic [1:0]  out_discs;
    logic [9:0]  out_number;
    logic [15:0] out_time_left;
    logic        insert_dropped;
  } out_item_t;

  typedef struct packed {
    logic [15:0] arrival;
    logic [2:0]  priority_level;
    logic [15:0] cpu_time;
    logic [13:0] memory;
    logic [5:0]  devices;
    logic [9:0]  number;
    logic [15:0] time_left;
  } entry_t;

  typedef struct packed {
    logic ins;
    logic pop;
  } cell_ctrl_t;

  typedef struct packed {
    logic   valid;
    logic   place;
    entry_t entry;
  } cell_link_t;

endpackage

`default_nettype wire

// ----- sv/sapq_cell.sv -----
// ----------------------------------------------------------------------------
// Sorted queue cell
// Holds one descriptor slot and shifts toward either neighbor on a command.
// ----------------------------------------------------------------------------
`default_nettype none

module sapq_cell (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire sapq_pkg::cell_ctrl_t ctrl,
  input  wire sapq_pkg::entry_t     new_entry,
  input  wire sapq_pkg::cell_link_t prev_link,
  input  wire sapq_pkg::cell_link_t next_link,
  output sapq_pkg::cell_link_t      own_link
);

  logic             valid_r;
  logic             valid_nxt;
  sapq_pkg::entry_t entry_r;
  sapq_pkg::entry_t entry_nxt;
  logic             greater;
  logic             place;

  always_comb begin
    greater = valid_r &&
              ((entry_r.arrival > new_entry.arrival) ||
               ((entry_r.arrival == new_entry.arrival) &&
                (entry_r.priority_level > new_entry.priority_level)));
    place = !valid_r || greater;
  end

  always_comb begin
    valid_nxt = valid_r;
    entry_nxt = entry_r;
    if (ctrl.ins && place) begin
      if (!prev_link.place) begin
        valid_nxt = 1'b1;
        entry_nxt = new_entry;
      end else begin
        valid_nxt = prev_link.valid;
        entry_nxt = prev_link.entry;
      end
    end else if (ctrl.pop) begin
      valid_nxt = next_link.valid;
      entry_nxt = next_link.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign own_link.valid = valid_r;
  assign own_link.place = place;
  assign own_link.entry = entry_r;

endmodule

`default_nettype wire

// ----- sv/sorted_arrival_priority_queue.sv -----
// ----------------------------------------------------------------------------
// Sorted arrival priority queue
// Bounded queue of process descriptors sorted by arrival, then priority.
// ----------------------------------------------------------------------------
// The input channel (in_valid, in_stall, in_data) carries one command per
// transfer. An insert places the descriptor behind all entries with an equal
// or smaller key; a pop removes the head. Every command yields exactly one
// result on the output channel (out_valid, out_stall, out_data). An insert
// into a full queue is discarded and reports insert_dropped; a pop of an
// empty queue reports head_valid low.
// The queue is a row of QUEUE_DEPTH cells that all compare against the new
// key in the same cycle and shift by one slot, so a command updates the whole
// queue at once. The result is registered and appears in the cycle after the
// input transfer, and one command per cycle is taken while the output register is free or drained.
// While out_stall is high with a result held, in_stall is high too.
// Reset empties the queue and discards any held result.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_arrival_priority_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire sapq_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output sapq_pkg::out_item_t      out_data
);

  localparam int Depth = sapq_pkg::QUEUE_DEPTH;

  sapq_pkg::cell_link_t link [Depth];
  sapq_pkg::cell_ctrl_t ctrl;
  sapq_pkg::entry_t     new_entry;
  sapq_pkg::cell_link_t head_tie;
  sapq_pkg::cell_link_t tail_tie;
  sapq_pkg::out_item_t  out_data_r;
  sapq_pkg::out_item_t  out_data_nxt;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  logic [Depth-1:0]     valid_vec;
  logic                 accept;
  logic                 full;
  logic                 is_pop;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign is_pop   = (in_data.command == sapq_pkg::CMD_POP);
  assign full     = link[Depth-1].valid;

  always_comb begin
    new_entry.arrival        = in_data.arrival_time;
    new_entry.priority_level = in_data.priority_level;
    new_entry.cpu_time       = in_data.cpu_time;
    new_entry.memory         = in_data.memory_need;
    new_entry.devices        = {in_data.discs_need, in_data.modems_need,
                                in_data.scanners_need, in_data.printers_need};
    new_entry.number         = in_data.process_number;
    new_entry.time_left      = in_data.time_left;
    ctrl.ins = accept && !is_pop && !full;
    ctrl.pop = accept && is_pop;
    head_tie.valid = 1'b1;
    head_tie.place = 1'b0;
    head_tie.entry = '0;
    tail_tie.valid = 1'b0;
    tail_tie.place = 1'b1;
    tail_tie.entry = '0;
  end

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    sapq_pkg::cell_link_t prev_l;
    sapq_pkg::cell_link_t next_l;
    if (i == 0) begin : g_first
      assign prev_l = head_tie;
    end else begin : g_mid_prev
      assign prev_l = link[i-1];
    end
    if (i == Depth - 1) begin : g_last
      assign next_l = tail_tie;
    end else begin : g_mid_next
      assign next_l = link[i+1];
    end
    sapq_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .new_entry (new_entry),
      .prev_link (prev_l),
      .next_link (next_l),
      .own_link  (link[i])
    );
    assign valid_vec[i] = link[i].valid;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (accept) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = '0;
      if (is_pop) begin
        if (link[0].valid) begin
          out_data_nxt.head_valid    = 1'b1;
          out_data_nxt.out_arrival   = link[0].entry.arrival;
          out_data_nxt.out_priority  = link[0].entry.priority_level;
          out_data_nxt.out_cpu_time  = link[0].entry.cpu_time;
          out_data_nxt.out_memory    = link[0].entry.memory;
          out_data_nxt.out_printers  = link[0].entry.devices[1:0];
          out_data_nxt.out_scanners  = link[0].entry.devices[2];
          out_data_nxt.out_modems    = link[0].entry.devices[3];
          out_data_nxt.out_discs     = link[0].entry.devices[5:4];
          out_data_nxt.out_number    = link[0].entry.number;
          out_data_nxt.out_time_left = link[0].entry.time_left;
        end
      end else begin
        out_data_nxt.insert_dropped = full;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_vec & (valid_vec + Depth'(1))) == '0)
    else $error("Occupied slots do not form a prefix of the queue.");

  a_drop_keeps_full: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !is_pop && full) |=> (full && out_data_r.insert_dropped))
    else $error("Dropped insert changed the queue or was not flagged.");

  a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_pop && !link[0].valid) |=>
      (!out_data_r.head_valid && (valid_vec == '0)))
    else $error("Pop of an empty queue returned a descriptor.");

  a_pop_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_pop && link[0].valid) |=>
      (out_data_r.head_valid && !out_data_r.insert_dropped))
    else $error("Pop of a nonempty queue did not return the head.");

endmodule

`default_nettype wire

// ----- tb/sapq_result_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted arrival priority queue result checker
// Watches both channels of the queue. Every accepted command updates a local
// model of the sorted queue, and its expected result is stored in order.
// Every accepted result is compared field by field with the oldest stored
// expectation.
// ----------------------------------------------------------------------------

module sapq_result_checker
  import sapq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_data,
  output int        error_count,
  output int        pending_results
);

  entry_t    held_entries [QUEUE_DEPTH];
  int        held_count;
  out_item_t due_results [$];

  initial begin
    error_count     = 0;
    pending_results = 0;
    held_count      = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
    end
  endtask

  task automatic apply_command(input in_item_t cmd, output out_item_t res);
    entry_t fresh;
    int     slot;
    res = '0;
    if (cmd.command == CMD_INSERT) begin
      if (held_count >= QUEUE_DEPTH) begin
        res.insert_dropped = 1'b1;
      end else begin
        fresh.arrival        = cmd.arrival_time;
        fresh.priority_level = cmd.priority_level;
        fresh.cpu_time       = cmd.cpu_time;
        fresh.memory         = cmd.memory_need;
        fresh.devices        = {cmd.discs_need, cmd.modems_need, cmd.scanners_need,
                                cmd.printers_need};
        fresh.number         = cmd.process_number;
        fresh.time_left      = cmd.time_left;
        slot = held_count;
        for (int i = held_count - 1; i >= 0; i--) begin
          if (held_entries[i].arrival > fresh.arrival ||
              (held_entries[i].arrival == fresh.arrival &&
               held_entries[i].priority_level > fresh.priority_level)) begin
            slot = i;
          end
        end
        for (int i = held_count; i > slot; i--) begin
          held_entries[i] = held_entries[i - 1];
        end
        held_entries[slot] = fresh;
        held_count++;
      end
    end else if (held_count > 0) begin
      res.head_valid    = 1'b1;
      res.out_arrival   = held_entries[0].arrival;
      res.out_priority  = held_entries[0].priority_level;
      res.out_cpu_time  = held_entries[0].cpu_time;
      res.out_memory    = held_entries[0].memory;
      res.out_printers  = held_entries[0].devices[1:0];
      res.out_scanners  = held_entries[0].devices[2];
      res.out_modems    = held_entries[0].devices[3];
      res.out_discs     = held_entries[0].devices[5:4];
      res.out_number    = held_entries[0].number;
      res.out_time_left = held_entries[0].time_left;
      for (int i = 0; i + 1 < held_count; i++) begin
        held_entries[i] = held_entries[i + 1];
      end
      held_count--;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    if (!rst_n) begin
      held_count = 0;
      due_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = out_data;
        if (due_results.size() == 0) begin
          report_mismatch("result transfer with no command outstanding");
        end else begin
          want = due_results.pop_front();
          check_field("head_valid", 16'(got.head_valid), 16'(want.head_valid));
          check_field("out_arrival", got.out_arrival, want.out_arrival);
          check_field("out_priority", 16'(got.out_priority), 16'(want.out_priority));
          check_field("out_cpu_time", got.out_cpu_time, want.out_cpu_time);
          check_field("out_memory", 16'(got.out_memory), 16'(want.out_memory));
          check_field("out_printers", 16'(got.out_printers), 16'(want.out_printers));
          check_field("out_scanners", 16'(got.out_scanners), 16'(want.out_scanners));
          check_field("out_modems", 16'(got.out_modems), 16'(want.out_modems));
          check_field("out_discs", 16'(got.out_discs), 16'(want.out_discs));
          check_field("out_number", 16'(got.out_number), 16'(want.out_number));
          check_field("out_time_left", got.out_time_left, want.out_time_left);
          check_field("insert_dropped", 16'(got.insert_dropped),
                      16'(want.insert_dropped));
        end
      end
      if (in_valid && !in_stall) begin
        apply_command(in_data, want);
        due_results.push_back(want);
      end
    end
    pending_results = due_results.size();
  end

endmodule

// ----- tb/tb_sorted_arrival_priority_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted arrival priority queue testbench
// Drives inserts and pops into the queue in bursts while the result side
// stalls on its own pattern. A directed opening covers ties, key extremes,
// a full queue and an empty pop; random phases with a shifting insert share
// then fill and drain the queue. The checker beside the block does all
// prediction and comparison.
// ----------------------------------------------------------------------------

module tb_sorted_arrival_priority_queue;
  import sapq_pkg::*;

  localparam int RANDOM_COMMANDS = 950;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  int        error_count;
  int        pending_results;
  int        burst_left;

  sorted_arrival_priority_queue uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  sapq_result_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .error_count     (error_count),
    .pending_results (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("tb_sorted_arrival_priority_queue: errors");
    $finish;
  end

  function automatic in_item_t descriptor(input cmd_t cmd, input logic [15:0] arrival,
                                          input logic [2:0] prio, input logic [9:0] number,
                                          input bit all_ones);
    in_item_t item;
    item = all_ones ? '1 : '0;
    item.command        = cmd;
    item.arrival_time   = arrival;
    item.priority_level = prio;
    item.process_number = number;
    return item;
  endfunction

  function automatic in_item_t random_command(input int insert_share);
    in_item_t     item;
    logic [127:0] noise;
    noise = {$urandom, $urandom, $urandom, $urandom};
    item = noise[$bits(in_item_t)-1:0];
    item.command = ($urandom_range(0, 99) < insert_share) ? CMD_INSERT : CMD_POP;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: item.arrival_time = 16'($urandom_range(0, 7));
      4:          item.arrival_time = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default:    item.arrival_time = 16'($urandom);
    endcase
    return item;
  endfunction

  task automatic transfer_command(input in_item_t item);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? 120 : $urandom_range(1, 24);
    end
    in_data  <= item;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
  endtask

  initial begin
    int stall_mode;
    out_stall <= 1'b0;
    forever begin
      stall_mode = $urandom_range(0, 2);
      repeat ($urandom_range(20, 80)) begin
        @(posedge clk);
        case (stall_mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 9) < 3);
          default: out_stall <= ($urandom_range(0, 7) == 0) ? ~out_stall : out_stall;
        endcase
      end
    end
  end

  initial begin
    int insert_share;
    int drain_cycles;
    in_valid   <= 1'b0;
    in_data    <= '0;
    rst_n      <= 1'b0;
    burst_left = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty pop, equal keys in insertion order, key and field extremes.
    transfer_command(descriptor(CMD_POP, 16'd0, 3'd0, 10'd0, 1'b0));
    transfer_command(descriptor(CMD_INSERT, 16'd100, 3'd3, 10'd1, 1'b0));
    transfer_command(descriptor(CMD_INSERT, 16'd100, 3'd3, 10'd2, 1'b1));
    transfer_command(descriptor(CMD_INSERT, 16'd100, 3'd0, 10'd3, 1'b0));
    transfer_command(descriptor(CMD_INSERT, 16'd100, 3'd7, 10'd4, 1'b1));
    transfer_command(descriptor(CMD_INSERT, 16'h0000, 3'd7, 10'h3FF, 1'b1));
    transfer_command(descriptor(CMD_INSERT, 16'hFFFF, 3'd0, 10'd0, 1'b0));
    transfer_command(descriptor(CMD_INSERT, 16'hFFFF, 3'd7, 10'd5, 1'b1));
    for (int i = 0; i < 9; i++) begin
      transfer_command(descriptor(CMD_INSERT, 16'd50 + i[15:0], i[2:0], 10'd10 + i[9:0],
                                  i[0]));
    end
    // The queue is full here, so this insert must be dropped.
    transfer_command(descriptor(CMD_INSERT, 16'd1, 3'd1, 10'd99, 1'b1));
    repeat (6) transfer_command(descriptor(CMD_POP, 16'd0, 3'd0, 10'd0, 1'b0));

    insert_share = 50;
    for (int n = 0; n < RANDOM_COMMANDS; n++) begin
      if (n % 40 == 0) begin
        insert_share = $urandom_range(15, 90);
      end
      transfer_command(random_command(insert_share));
    end
    in_valid <= 1'b0;

    drain_cycles = 0;
    while (pending_results != 0 && drain_cycles < 20000) begin
      @(posedge clk);
      drain_cycles++;
    end
    if (pending_results != 0) begin
      $display("tb_sorted_arrival_priority_queue: errors");
      $finish;
    end else begin
      repeat (8) @(posedge clk);
      if (error_count == 0) begin
        $display("tb_sorted_arrival_priority_queue: clean");
      end else begin
        $display("tb_sorted_arrival_priority_queue: errors");
      end
      $finish;
    end
  end

endmodule

// ----- filelist.f -----
sv/sapq_pkg.sv
sv/sapq_cell.sv
sv/sorted_arrival_priority_queue.sv
tb/sapq_result_checker.sv
tb/tb_sorted_arrival_priority_queue.sv
